### hw/rtl/rlm_pkg.sv
// Shared widths, constants and unit request/response types for the RMS level meter.
`default_nettype none

package rlm_pkg;

   localparam int SUM_W     = 48;
   localparam int TOTAL_W   = 16;
   localparam int LVL_W     = 16;
   localparam int SCALE_W   = 17;
   localparam int SEG_W     = 4;

   localparam int DIV_W     = SUM_W + 2;
   localparam int DIVR_W    = 16;
   localparam int DIV_CNT_W = 6;

   localparam int SQ_IN_W   = 32;
   localparam int SQ_OUT_W  = 16;
   localparam int SQ_CNT_W  = 5;

   localparam logic [SCALE_W-1:0] ONE_Q16 = 17'h10000;
   localparam int SEG_COUNT = 10;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  dividend;
      logic [DIVR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic               start;
      logic [SQ_IN_W-1:0] operand;
   } sqrt_req_type;

   typedef struct packed {
      logic                done;
      logic [SQ_OUT_W-1:0] root;
   } sqrt_rsp_type;

endpackage

`default_nettype wire

### hw/rtl/rlm_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module rlm_div
   import rlm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output      div_rsp_type rsp
);

   logic [DIV_W-1:0]     acc_ff, acc_in;
   logic [DIVR_W-1:0]    dvs_ff, dvs_in;
   logic [DIVR_W-1:0]    rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIVR_W:0]      shifted;
   logic [DIVR_W:0]      diff;
   logic                 take;

   always_comb begin
      shifted = {rem_ff, acc_ff[DIV_W-1]};
      take    = shifted >= {1'b0, dvs_ff};
      diff    = shifted - {1'b0, dvs_ff};
      acc_in  = acc_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         acc_in  = req.dividend;
         dvs_in  = req.divisor;
         rem_in  = '0;
         cnt_in  = DIV_CNT_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = {acc_ff[DIV_W-2:0], take};
         rem_in = take ? diff[DIVR_W-1:0] : shifted[DIVR_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = acc_ff;

endmodule

`default_nettype wire

### hw/rtl/rlm_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
`default_nettype none

module rlm_sqrt
   import rlm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire sqrt_req_type req,
   output      sqrt_rsp_type rsp
);

   logic [SQ_IN_W-1:0]  op_ff, op_in;
   logic [SQ_OUT_W-1:0] root_ff, root_in;
   logic [SQ_OUT_W:0]   rem_ff, rem_in;
   logic [SQ_CNT_W-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [SQ_OUT_W+2:0] rem_t;
   logic [SQ_OUT_W+2:0] trial;
   logic [SQ_OUT_W+2:0] diff;
   logic                take;

   always_comb begin
      rem_t   = {rem_ff, op_ff[SQ_IN_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      take    = rem_t >= trial;
      diff    = rem_t - trial;
      op_in   = op_ff;
      root_in = root_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         op_in   = req.operand;
         root_in = '0;
         rem_in  = '0;
         cnt_in  = SQ_CNT_W'(SQ_OUT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         op_in   = {op_ff[SQ_IN_W-3:0], 2'b00};
         root_in = {root_ff[SQ_OUT_W-2:0], take};
         rem_in  = take ? diff[SQ_OUT_W:0] : rem_t[SQ_OUT_W:0];
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == SQ_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
   end

   assign rsp.done = done_ff;
   assign rsp.root = root_ff;

endmodule

`default_nettype wire

### hw/rtl/multichannel_rms_level_meter_core.sv
// Multichannel RMS level meter: per-channel square sums and smoothed levels in memories.
// A sample transaction is taken when idle; an in-use sample updates its sum in the next cycle,
// so the next sample waits for it; an unused channel's sample delays it only at a buffer end.
// On a buffer end, each channel in use gives one report in turn, each computed with two
// 50-step runs of the shared divider and one 16-step run of the square root unit.
// Reset restores register defaults; valid bits make all sums and levels read as zero.
`default_nettype none

module multichannel_rms_level_meter_core
   import rlm_pkg::*;
#(
   parameter int MAX_CHANNELS = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire logic [2:0]         req_channel,
   input  wire logic signed [15:0] req_sample,
   input  wire logic               req_block_end,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      logic [2:0]         rsp_out_channel,
   output      logic [LVL_W-1:0]   rsp_smoothed_level,
   output      logic [SCALE_W-1:0] rsp_scaled_level,
   output      logic [SEG_W-1:0]   rsp_lit_segments,
   output      logic               rsp_last_report,
   input  wire logic               csr_valid,
   output      logic               csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_wdata
);

   localparam int DEPTH = (MAX_CHANNELS < 8) ? MAX_CHANNELS : 8;
   localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [1:0] CSR_CHANNELS   = 2'd0;
   localparam logic [1:0] CSR_FULL_SCALE = 2'd1;
   localparam logic [1:0] CSR_DECAY      = 2'd2;

   typedef enum logic [10:0] {
      S_IDLE   = 11'b000_0000_0001,
      S_ACC    = 11'b000_0000_0010,
      S_RD     = 11'b000_0000_0100,
      S_MEAN   = 11'b000_0000_1000,
      S_DIVM   = 11'b000_0001_0000,
      S_SQRT   = 11'b000_0010_0000,
      S_MUL1   = 11'b000_0100_0000,
      S_MUL2   = 11'b000_1000_0000,
      S_SMOOTH = 11'b001_0000_0000,
      S_DIVS   = 11'b010_0000_0000,
      S_EMIT   = 11'b100_0000_0000
   } state_type;

   state_type            state_ff, state_in;
   logic [IW-1:0]        idx_ff, idx_in;
   logic [IW-1:0]        ch_ff;
   logic                 end_ff;
   logic [31:0]          square_ff;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic [DEPTH-1:0]     sum_vld_ff, sum_vld_in;
   logic [DEPTH-1:0]     sm_vld_ff, sm_vld_in;
   logic [3:0]           chan_cfg_ff;
   logic [15:0]          fs_cfg_ff;
   logic [15:0]          decay_cfg_ff;

   logic [SUM_W-1:0]     sum_mem_ff [DEPTH];
   logic [LVL_W-1:0]     sm_mem_ff [DEPTH];
   logic [SUM_W-1:0]     sum_rdata_ff;
   logic [LVL_W-1:0]     sm_rdata_ff;
   logic                 sum_rvld_ff;
   logic                 sm_rvld_ff;

   logic [LVL_W-1:0]     sm_old_ff, sm_old_in;
   logic                 rms_sat_ff, rms_sat_in;
   logic [LVL_W-1:0]     rms_ff, rms_in;
   logic [32:0]          prod_ff, prod_in;
   logic [LVL_W-1:0]     smooth_ff, smooth_in;
   logic [SCALE_W-1:0]   scaled_ff, scaled_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [2:0]           rsp_ch_ff;
   logic [LVL_W-1:0]     rsp_sm_ff;
   logic [SCALE_W-1:0]   rsp_scaled_ff;
   logic [SEG_W-1:0]     rsp_seg_ff;
   logic                 rsp_last_ff;

   logic [3:0]           eff_n;
   logic                 req_fire;
   logic                 ch_in_use;
   logic                 last_ch;
   logic                 load;
   logic signed [31:0]   sq_s;
   logic [SUM_W-1:0]     sum_cur;
   logic [SUM_W:0]       sum_add;
   logic                 sum_rd_en;
   logic [IW-1:0]        sum_rd_addr;
   logic                 sum_wr_en;
   logic [SUM_W-1:0]     sum_wr_data;
   logic                 sm_rd_en;
   logic                 sm_wr_en;
   logic [16:0]          keep_new;
   logic [32:0]          rnd;
   logic [19:0]          seg_prod;
   logic [15:0]          fs_eff;
   div_req_type          div_req;
   div_rsp_type          div_rsp;
   sqrt_req_type         sqrt_req;
   sqrt_rsp_type         sqrt_rsp;

   rlm_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   rlm_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .req   (sqrt_req),
      .rsp   (sqrt_rsp)
   );

   always_comb begin
      eff_n = (chan_cfg_ff == 4'd0) ? 4'd1 : chan_cfg_ff;
      if (eff_n > 4'(DEPTH)) begin
         eff_n = 4'(DEPTH);
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign ch_in_use = {1'b0, req_channel} < eff_n;
   assign last_ch   = 4'(idx_ff) == (eff_n - 4'd1);
   assign load      = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign sq_s      = req_sample * req_sample;
   assign sum_cur   = sum_rvld_ff ? sum_rdata_ff : '0;
   assign sum_add   = {1'b0, sum_cur} + (SUM_W+1)'(square_ff);
   assign sum_wr_data = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
   assign keep_new  = ONE_Q16 - 17'(decay_cfg_ff);
   assign rnd       = prod_ff + 33'(32768);
   assign seg_prod  = 20'(scaled_ff) * 20'(SEG_COUNT);
   assign fs_eff    = (fs_cfg_ff == 16'd0) ? 16'd1 : fs_cfg_ff;

   assign sum_rd_en   = (req_fire && ch_in_use) || (state_ff == S_RD);
   assign sum_rd_addr = (state_ff == S_RD) ? idx_ff : req_channel[IW-1:0];
   assign sum_wr_en   = (state_ff == S_ACC);
   assign sm_rd_en    = (state_ff == S_RD);
   assign sm_wr_en    = (state_ff == S_SMOOTH);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      total_in     = total_ff;
      sum_vld_in   = sum_vld_ff;
      sm_vld_in    = sm_vld_ff;
      sm_old_in    = sm_old_ff;
      rms_sat_in   = rms_sat_ff;
      rms_in       = rms_ff;
      prod_in      = prod_ff;
      smooth_in    = smooth_ff;
      scaled_in    = scaled_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      div_req      = '0;
      sqrt_req     = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (ch_in_use) begin
                  state_in = S_ACC;
               end else if (req_block_end) begin
                  state_in = S_RD;
               end
               idx_in = '0;
            end
         end
         S_ACC: begin
            sum_vld_in[ch_ff] = 1'b1;
            if (total_ff != '1) begin
               total_in = total_ff + 1'b1;
            end
            state_in = end_ff ? S_RD : S_IDLE;
         end
         S_RD: begin
            state_in = S_MEAN;
         end
         S_MEAN: begin
            sm_old_in        = sm_rvld_ff ? sm_rdata_ff : '0;
            div_req.start    = 1'b1;
            div_req.dividend = {sum_cur, 2'b00};
            div_req.divisor  = total_ff;
            state_in         = S_DIVM;
         end
         S_DIVM: begin
            if (div_rsp.done) begin
               sqrt_req.start = 1'b1;
               if (total_ff == '0) begin
                  sqrt_req.operand = '0;
                  rms_sat_in       = 1'b0;
               end else begin
                  sqrt_req.operand = div_rsp.quotient[SQ_IN_W-1:0];
                  rms_sat_in       = |div_rsp.quotient[DIV_W-1:SQ_IN_W];
               end
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            if (sqrt_rsp.done) begin
               rms_in   = rms_sat_ff ? '1 : sqrt_rsp.root;
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            prod_in  = 33'(decay_cfg_ff) * 33'(sm_old_ff);
            state_in = S_MUL2;
         end
         S_MUL2: begin
            prod_in  = prod_ff + 33'(keep_new) * 33'(rms_ff);
            state_in = S_SMOOTH;
         end
         S_SMOOTH: begin
            smooth_in         = rnd[31:16];
            sm_vld_in[idx_ff] = 1'b1;
            div_req.start     = 1'b1;
            div_req.dividend  = DIV_W'({rnd[31:16], 16'h0000});
            div_req.divisor   = fs_eff;
            state_in          = S_DIVS;
         end
         S_DIVS: begin
            if (div_rsp.done) begin
               if (div_rsp.quotient > DIV_W'(ONE_Q16)) begin
                  scaled_in = ONE_Q16;
               end else begin
                  scaled_in = div_rsp.quotient[SCALE_W-1:0];
               end
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               if (last_ch) begin
                  sum_vld_in = '0;
                  total_in   = '0;
                  state_in   = S_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         total_ff     <= '0;
         sum_vld_ff   <= '0;
         sm_vld_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         chan_cfg_ff  <= 4'd2;
         fs_cfg_ff    <= 16'd11141;
         decay_cfg_ff <= 16'd60948;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         total_ff     <= total_in;
         sum_vld_ff   <= sum_vld_in;
         sm_vld_ff    <= sm_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CHANNELS:   chan_cfg_ff  <= csr_wdata[3:0];
               CSR_FULL_SCALE: fs_cfg_ff    <= csr_wdata;
               CSR_DECAY:      decay_cfg_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         ch_ff     <= req_channel[IW-1:0];
         end_ff    <= req_block_end;
         square_ff <= 32'(sq_s);
      end
   end

   always_ff @(posedge clock) begin
      if (sum_wr_en) begin
         sum_mem_ff[ch_ff] <= sum_wr_data;
      end
      if (sum_rd_en) begin
         sum_rdata_ff <= sum_mem_ff[sum_rd_addr];
         sum_rvld_ff  <= sum_vld_ff[sum_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (sm_wr_en) begin
         sm_mem_ff[idx_ff] <= rnd[31:16];
      end
      if (sm_rd_en) begin
         sm_rdata_ff <= sm_mem_ff[idx_ff];
         sm_rvld_ff  <= sm_vld_ff[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      sm_old_ff  <= sm_old_in;
      rms_sat_ff <= rms_sat_in;
      rms_ff     <= rms_in;
      prod_ff    <= prod_in;
      smooth_ff  <= smooth_in;
      scaled_ff  <= scaled_in;
      if (load) begin
         rsp_ch_ff     <= 3'(idx_ff);
         rsp_sm_ff     <= smooth_ff;
         rsp_scaled_ff <= scaled_ff;
         rsp_seg_ff    <= seg_prod[SEG_W+15:16];
         rsp_last_ff   <= last_ch;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_channel    = rsp_ch_ff;
   assign rsp_smoothed_level = rsp_sm_ff;
   assign rsp_scaled_level   = rsp_scaled_ff;
   assign rsp_lit_segments   = rsp_seg_ff;
   assign rsp_last_report    = rsp_last_ff;

`ifndef SYNTHESIS
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff));

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_channel) &&
         $stable(rsp_smoothed_level) && $stable(rsp_scaled_level) &&
         $stable(rsp_lit_segments) && $stable(rsp_last_report));

   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_lit_segments <= 4'(SEG_COUNT) && rsp_scaled_level <= ONE_Q16);

   a_sum_port: assert property (@(posedge clock) disable iff (reset)
      !(sum_rd_en && sum_wr_en));
`endif

endmodule

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the multichannel RMS level meter core.
module testbench;
   import rlm_pkg::*;

   typedef enum logic [1:0] {
      REG_CHANNELS   = 2'd0,
      REG_FULL_SCALE = 2'd1,
      REG_DECAY      = 2'd2,
      REG_UNMAPPED   = 2'd3
   } meter_reg_type;

   typedef struct {
      logic [2:0]         channel;
      logic signed [15:0] sample;
      logic               block_end;
      logic               drain_first;
   } audio_sample_type;

   typedef struct {
      logic [2:0]         channel;
      logic [LVL_W-1:0]   smoothed;
      logic [SCALE_W-1:0] scaled;
      logic [SEG_W-1:0]   segments;
      logic               last;
   } level_report_type;

   localparam int CLOCK_HALF       = 6;
   localparam int METER_CHANNELS   = 8;
   localparam int SETTLE_CYCLES    = 20;
   localparam int DRAIN_CYCLES     = 300;
   localparam int BURST_SAMPLES    = 8;
   localparam int REPORT_LIMIT     = 10;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [2:0]          req_channel = '0;
   logic signed [15:0]  req_sample = '0;
   logic                req_block_end = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [2:0]          rsp_out_channel;
   logic [LVL_W-1:0]    rsp_smoothed_level;
   logic [SCALE_W-1:0]  rsp_scaled_level;
   logic [SEG_W-1:0]    rsp_lit_segments;
   logic                rsp_last_report;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [1:0]          csr_index = '0;
   logic [15:0]         csr_wdata = '0;

   logic [47:0]         square_sums [METER_CHANNELS] = '{default: '0};
   logic [15:0]         smoothed_levels [METER_CHANNELS] = '{default: '0};
   logic [15:0]         sample_total = '0;
   logic [3:0]          chan_setting = 4'd2;
   logic [15:0]         full_scale = 16'd11141;
   logic [15:0]         decay_keep = 16'd60948;

   audio_sample_type    sample_queue [$];
   level_report_type    level_reports [$];
   int unsigned         samples_queued = 0;
   int unsigned         samples_accepted = 0;
   int unsigned         reports_seen = 0;
   int unsigned         reg_writes = 0;
   int unsigned         mismatches = 0;
   int unsigned         idle_rate = 0;
   int unsigned         gap_left = 0;
   int unsigned         stall_left = 0;

   multichannel_rms_level_meter_core #(
      .MAX_CHANNELS(METER_CHANNELS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_channel(req_channel),
      .req_sample(req_sample),
      .req_block_end(req_block_end),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_channel(rsp_out_channel),
      .rsp_smoothed_level(rsp_smoothed_level),
      .rsp_scaled_level(rsp_scaled_level),
      .rsp_lit_segments(rsp_lit_segments),
      .rsp_last_report(rsp_last_report),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #(CLOCK_HALF) clock = 1'b1;
      #(CLOCK_HALF) clock = 1'b0;
   end

   function automatic int unsigned active_channels();
      if (chan_setting == 0) return 1;
      if (chan_setting > METER_CHANNELS) return METER_CHANNELS;
      return chan_setting;
   endfunction

   function automatic longint unsigned floor_root(input longint unsigned x);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = 26; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= x) r = t;
      end
      return r;
   endfunction

   task automatic meter_sample(input logic [2:0] ch, input logic signed [15:0] smp,
                               input logic blk_end);
      int unsigned     n;
      logic signed [31:0] wide;
      logic [48:0]     acc;
      longint unsigned mean;
      longint unsigned rms;
      longint unsigned keep;
      longint unsigned blend;
      longint unsigned lvl;
      longint unsigned scaled;
      longint unsigned fs;
      level_report_type rep;
      n = active_channels();
      if (ch < n) begin
         wide = smp;
         acc = {1'b0, square_sums[ch]} + 49'(wide * wide);
         square_sums[ch] = acc[48] ? {48{1'b1}} : acc[47:0];
         if (sample_total != 16'hFFFF) sample_total++;
      end
      if (blk_end) begin
         fs = (full_scale == 0) ? 1 : full_scale;
         keep = decay_keep;
         for (int i = 0; i < n; i++) begin
            mean = 0;
            if (sample_total != 0) mean = {square_sums[i], 2'b00} / sample_total;
            rms = floor_root(mean);
            if (rms > 65535) rms = 65535;
            blend = (keep * smoothed_levels[i] + (64'd65536 - keep) * rms + 64'd32768) >> 16;
            lvl = (blend > 65535) ? 64'd65535 : blend;
            smoothed_levels[i] = lvl[15:0];
            scaled = (lvl << 16) / fs;
            if (scaled > ONE_Q16) scaled = ONE_Q16;
            rep.channel = 3'(i);
            rep.smoothed = lvl[15:0];
            rep.scaled = scaled[16:0];
            rep.segments = 4'((scaled * SEG_COUNT) >> 16);
            rep.last = (i + 1 == n);
            level_reports.insert(level_reports.size(), rep);
         end
         square_sums = '{default: '0};
         sample_total = '0;
      end
   endtask

   always @(posedge clock) begin
      audio_sample_type item;
      logic launch;
      launch = 1'b0;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && req_ready) begin
            meter_sample(req_channel, req_sample, req_block_end);
            samples_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (sample_queue.size() != 0 &&
                         !(sample_queue[0].drain_first && level_reports.size() != 0)) begin
               item = sample_queue.pop_front();
               req_channel <= item.channel;
               req_sample <= item.sample;
               req_block_end <= item.block_end;
               launch = 1'b1;
               if (idle_rate != 0 && $urandom_range(1, 100) <= idle_rate)
                  gap_left = $urandom_range(1, 14);
            end
            req_valid <= launch;
         end
      end
   end

   always @(posedge clock) begin
      level_report_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            reports_seen++;
            if (level_reports.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("unexpected report: ch %0d smoothed %0d scaled %0d segs %0d last %0d",
                           rsp_out_channel, rsp_smoothed_level, rsp_scaled_level,
                           rsp_lit_segments, rsp_last_report);
            end else begin
               want = level_reports.pop_front();
               if (rsp_out_channel !== want.channel || rsp_smoothed_level !== want.smoothed ||
                   rsp_scaled_level !== want.scaled || rsp_lit_segments !== want.segments ||
                   rsp_last_report !== want.last) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("report mismatch: expected ch %0d smoothed %0d scaled %0d segs %0d last %0d",
                              want.channel, want.smoothed, want.scaled, want.segments,
                              want.last);
                     $display("                 got      ch %0d smoothed %0d scaled %0d segs %0d last %0d",
                              rsp_out_channel, rsp_smoothed_level, rsp_scaled_level,
                              rsp_lit_segments, rsp_last_report);
                  end
               end
            end
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idle_rate != 0 && $urandom_range(1, 100) <= idle_rate) begin
            stall_left = $urandom_range(0, 13);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic write_reg(input meter_reg_type idx, input logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      reg_writes++;
      case (idx)
         REG_CHANNELS:   chan_setting = value[3:0];
         REG_FULL_SCALE: full_scale = value;
         REG_DECAY:      decay_keep = value;
         default: ;
      endcase
   endtask

   task automatic add_sample(input logic [2:0] ch, input logic signed [15:0] smp,
                             input logic blk_end, input logic drain);
      audio_sample_type item;
      item.channel = ch;
      item.sample = smp;
      item.block_end = blk_end;
      item.drain_first = drain;
      sample_queue.insert(sample_queue.size(), item);
      samples_queued++;
   endtask

   task automatic settle();
      while (samples_accepted != samples_queued || level_reports.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         1:       return 16'($urandom_range(0, 511) - 256);
         2:       return 16'($urandom);
         default: return {$urandom_range(0, 1) ? 2'b10 : 2'b01, 14'($urandom)};
      endcase
   endfunction

   task automatic random_phase(input int unsigned item_goal);
      int unsigned made;
      int unsigned n;
      int unsigned frames;
      logic [2:0]  ch;
      made = 0;
      n = active_channels();
      while (made < item_goal) begin
         if ($urandom_range(0, 7) == 0) begin
            ch = 3'($urandom);
            add_sample(ch, pick_sample(), $urandom_range(0, 3) == 0, 1'b0);
            if (ch < n) made++;
         end else begin
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
               for (int c = 0; c < n; c++) begin
                  add_sample(3'(c), pick_sample(), f == frames - 1 && c == n - 1,
                             c == 0 && $urandom_range(0, 19) == 0);
                  made++;
               end
            end
         end
      end
   endtask

   initial begin
      int unsigned round;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      idle_rate = 15;
      add_sample(3'd7, 16'sh7FFF, 1'b1, 1'b0);
      add_sample(3'd0, 16'sh8000, 1'b0, 1'b0);
      add_sample(3'd1, 16'sh7FFF, 1'b0, 1'b0);
      add_sample(3'd0, -16'sd1, 1'b0, 1'b0);
      add_sample(3'd1, 16'sd1, 1'b0, 1'b0);
      add_sample(3'd2, 16'sd1234, 1'b0, 1'b0);
      add_sample(3'd1, 16'sd0, 1'b1, 1'b0);
      add_sample(3'd0, 16'sd0, 1'b1, 1'b1);

      settle();
      write_reg(REG_CHANNELS, 16'd8);
      write_reg(REG_FULL_SCALE, 16'd1);
      write_reg(REG_DECAY, 16'd0);
      add_sample(3'd0, 16'sh8000, 1'b0, 1'b0);
      add_sample(3'd1, 16'sh7FFF, 1'b0, 1'b0);
      add_sample(3'd2, -16'sd1, 1'b0, 1'b0);
      add_sample(3'd3, 16'sh5555, 1'b0, 1'b0);
      add_sample(3'd4, 16'shAAAA, 1'b0, 1'b0);
      add_sample(3'd5, 16'sh00FF, 1'b0, 1'b0);
      add_sample(3'd6, 16'shFF00, 1'b0, 1'b0);
      add_sample(3'd7, 16'sh0001, 1'b1, 1'b0);
      add_sample(3'd0, 16'sh8000, 1'b1, 1'b0);

      settle();
      write_reg(REG_CHANNELS, 16'd0);
      write_reg(REG_FULL_SCALE, 16'd0);
      write_reg(REG_DECAY, 16'hFFFF);
      add_sample(3'd0, 16'sd12345, 1'b0, 1'b0);
      add_sample(3'd3, -16'sd5, 1'b0, 1'b0);
      add_sample(3'd0, 16'sh8000, 1'b1, 1'b0);

      settle();
      write_reg(REG_CHANNELS, {12'($urandom), 4'd15});
      write_reg(REG_FULL_SCALE, 16'hFFFF);
      write_reg(REG_DECAY, 16'h8000);
      write_reg(REG_UNMAPPED, 16'($urandom));
      add_sample(3'd5, 16'sh7FFF, 1'b0, 1'b0);
      add_sample(3'd6, 16'sh4000, 1'b0, 1'b0);
      add_sample(3'd7, 16'sh8000, 1'b1, 1'b0);

      for (round = 0; round < 4; round++) begin
         settle();
         write_reg(REG_CHANNELS, {12'($urandom),
                   4'(round == 2 ? $urandom_range(9, 15) : $urandom_range(1, 8))});
         write_reg(REG_FULL_SCALE, $urandom_range(0, 3) == 0 ?
                   16'($urandom_range(1, 2000)) : 16'($urandom));
         write_reg(REG_DECAY, 16'($urandom));
         idle_rate = (round == 1) ? 0 : $urandom_range(10, 30);
         random_phase(18);
      end

      // Drive a burst of full-scale samples on a single channel.
      settle();
      idle_rate = 0;
      write_reg(REG_CHANNELS, 16'd1);
      write_reg(REG_FULL_SCALE, 16'd40000);
      write_reg(REG_DECAY, 16'd16384);
      for (int k = 0; k < BURST_SAMPLES; k++)
         add_sample(3'd0, 16'sh8000, k == BURST_SAMPLES - 1, 1'b0);

      settle();
      write_reg(REG_CHANNELS, 16'd4);
      write_reg(REG_FULL_SCALE, 16'd11141);
      write_reg(REG_DECAY, 16'd60948);
      random_phase(12);

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Run covered %0d accepted samples and %0d level reports over %0d register writes,",
               samples_accepted, reports_seen, reg_writes);
      $display("including idle channels, empty buffers, clamped levels and full-scale bursts.");
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("timeout waiting for transactions to complete");
      $display("Some tests failed");
      $finish;
   end

endmodule

### sim.f
hw/rtl/rlm_pkg.sv
hw/rtl/rlm_div.sv
hw/rtl/rlm_sqrt.sv
hw/rtl/multichannel_rms_level_meter_core.sv
verif/testbench.sv
